>>> design/rau_pkg.sv
// ============================================================================
// rau_pkg: shared types and constants for the rational arithmetic unit
// Holds payload structs, mode codes and the sequencer state type.
// ============================================================================
package rau_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_EQ  = 3'd4,
        MODE_LT  = 3'd5
    } mode_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_numerator;
        logic signed [31:0] a_denominator;
        logic signed [31:0] b_numerator;
        logic signed [31:0] b_denominator;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] res_numerator;
        logic signed [31:0] res_denominator;
        logic               compare_true;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMBINE,
        ST_GCD_CHECK,
        ST_GCD_STEP,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Control from the sequencer to the shared datapath.
    typedef struct packed {
        logic load;
        logic mul_first;
        logic mul_second;
        logic mul_third;
        logic combine;
        logic gcd_start;
        logic gcd_go;
        logic div_num;
        logic div_den;
        logic finish;
    } ctrl_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic early_done;
        logic gcd_zero;
        logic div_busy;
        logic div_done;
    } stat_t;

endpackage

>>> design/rau_divider.sv
// ============================================================================
// rau_divider: shared restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle.
// ============================================================================
module rau_divider
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [rau_pkg::VALUE_WIDTH-1:0]        dividend,
    input  logic [rau_pkg::VALUE_WIDTH-1:0]        divisor,
    output logic                                   busy,
    output logic                                   done,
    output logic [rau_pkg::VALUE_WIDTH-1:0]        quotient,
    output logic [rau_pkg::VALUE_WIDTH-1:0]        remainder
);

    localparam int W  = rau_pkg::VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> design/rau_datapath.sv
// ============================================================================
// rau_datapath: operand registers, shared multiplier and reduction logic
// One signed multiplier serves all cross products; the divider serves GCD.
// ============================================================================
module rau_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::in_item_t  in_item,
    input  rau_pkg::ctrl_t     ctrl,
    output rau_pkg::stat_t     stat,
    output rau_pkg::out_item_t result
);

    localparam int W = rau_pkg::VALUE_WIDTH;
    localparam int P = rau_pkg::PROD_WIDTH;

    logic [2:0]          mode_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [P-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [W-1:0] num_reg, den_reg;
    logic [W-1:0]        mn_reg, md_reg;
    logic                neg_reg;
    logic [W-1:0]        gx_reg, gy_reg;
    logic                early_reg;
    rau_pkg::out_item_t  res_reg;

    logic signed [W-1:0] mul_a, mul_b;
    logic signed [P-1:0] mul_p;
    logic                valid_in;
    logic                is_cmp;

    logic                div_start;
    logic [W-1:0]        div_dvd, div_dvs, div_q, div_r;
    logic                div_busy, div_done;

    assign valid_in = (ad_reg != '0) && (bd_reg != '0);
    assign is_cmp   = (mode_reg == rau_pkg::MODE_EQ) || (mode_reg == rau_pkg::MODE_LT);

    // Operand select for the single shared multiplier.
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        if (ctrl.mul_second)
        begin
            if (mode_reg == rau_pkg::MODE_MUL)
            begin
                mul_a = an_reg;
                mul_b = bn_reg;
            end
            else
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
        end
        else if (ctrl.mul_third)
        begin
            mul_a = ad_reg;
            mul_b = (mode_reg == rau_pkg::MODE_DIV) ? bn_reg : bd_reg;
        end
    end
    assign mul_p = mul_a * mul_b;

    assign div_start = ctrl.gcd_go || ctrl.div_num || ctrl.div_den;
    always_comb
    begin
        div_dvd = gx_reg;
        div_dvs = gy_reg;
        if (ctrl.div_num)
        begin
            div_dvd = mn_reg;
            div_dvs = gx_reg;
        end
        else if (ctrl.div_den)
        begin
            div_dvd = md_reg;
            div_dvs = gx_reg;
        end
    end

    rau_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    logic signed [W-1:0] comb_num, comb_den;
    logic                early_next;
    logic [W-1:0]        mag_num, mag_den;
    logic                sign_lt;

    always_comb
    begin
        comb_num = p1_reg[W-1:0];
        comb_den = p2_reg[W-1:0];
        case (mode_reg)
            rau_pkg::MODE_ADD: comb_num = p0_reg[W-1:0] + p1_reg[W-1:0];
            rau_pkg::MODE_SUB: comb_num = p0_reg[W-1:0] - p1_reg[W-1:0];
            rau_pkg::MODE_MUL: comb_num = p1_reg[W-1:0];
            rau_pkg::MODE_DIV: comb_num = p0_reg[W-1:0];
            default:           comb_num = p0_reg[W-1:0];
        endcase
        mag_num = comb_num[W-1] ? W'(-comb_num) : W'(comb_num);
        mag_den = comb_den[W-1] ? W'(-comb_den) : W'(comb_den);
        early_next = (comb_den == '0) || (comb_num == '0);
    end

    // Exact compare: a_n*b_d versus b_n*a_d, sense flipped on negative d*d.
    assign sign_lt = (p0_reg < p1_reg) ^ (ad_reg[W-1] ^ bd_reg[W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            early_reg <= 1'b0;
        else if (ctrl.load)
            early_reg <= 1'b0;
        else if (ctrl.combine)
            early_reg <= !valid_in || is_cmp || mode_reg > rau_pkg::MODE_LT || early_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mode_reg <= in_item.mode;
            an_reg   <= W'(in_item.a_numerator);
            ad_reg   <= W'(in_item.a_denominator);
            bn_reg   <= W'(in_item.b_numerator);
            bd_reg   <= W'(in_item.b_denominator);
        end
        if (ctrl.mul_first)
            p0_reg <= mul_p;
        if (ctrl.mul_second)
            p1_reg <= mul_p;
        if (ctrl.mul_third)
            p2_reg <= mul_p;
        if (ctrl.combine)
        begin
            num_reg <= comb_num;
            den_reg <= comb_den;
            mn_reg  <= mag_num;
            md_reg  <= mag_den;
            neg_reg <= comb_num[W-1] ^ comb_den[W-1];
            gx_reg  <= mag_num;
            gy_reg  <= mag_den;
        end
        if (ctrl.gcd_start && div_done)
        begin
            gx_reg <= gy_reg;
            gy_reg <= div_r;
        end
        // The reduced numerator still sits in the quotient register when the
        // denominator division starts.
        if (ctrl.div_den)
            mn_reg <= div_q;
        if (ctrl.finish)
        begin
            res_reg.compare_true    <= 1'b0;
            res_reg.res_numerator   <= '0;
            res_reg.res_denominator <= '0;
            if (mode_reg <= rau_pkg::MODE_DIV)
            begin
                if (!valid_in || den_reg == '0)
                begin
                    res_reg.res_numerator   <= 32'sd1;
                    res_reg.res_denominator <= 32'sd0;
                end
                else if (num_reg == '0)
                begin
                    res_reg.res_numerator   <= 32'sd0;
                    res_reg.res_denominator <= 32'sd1;
                end
                else if (div_q[W-1] || (!neg_reg && mn_reg[W-1]))
                begin
                    res_reg.res_numerator   <= 32'sd1;
                    res_reg.res_denominator <= 32'sd0;
                end
                else
                begin
                    res_reg.res_numerator   <= neg_reg ? -mn_reg : mn_reg;
                    res_reg.res_denominator <= div_q;
                end
            end
            else if (is_cmp && valid_in)
            begin
                res_reg.compare_true <= (mode_reg == rau_pkg::MODE_EQ) ?
                                        (p0_reg == p1_reg) : (sign_lt && p0_reg != p1_reg);
            end
        end
    end

    assign stat.early_done = early_reg;
    assign stat.gcd_zero   = (gy_reg == '0);
    assign stat.div_busy   = div_busy;
    assign stat.div_done   = div_done;
    assign result          = res_reg;

endmodule

>>> design/rau_sequencer.sv
// ============================================================================
// rau_sequencer: control state machine for one item at a time
// Steps multiplies, the GCD loop and the two reducing divisions.
// ============================================================================
module rau_sequencer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           out_fire,
    input  rau_pkg::stat_t stat,
    output rau_pkg::ctrl_t ctrl,
    output logic           in_ready,
    output logic           out_valid
);

    rau_pkg::state_t state_reg, state_next;
    logic            wait_reg, wait_next;

    always_comb
    begin
        state_next = state_reg;
        wait_next  = 1'b0;
        case (state_reg)
            rau_pkg::ST_IDLE:      if (in_fire) state_next = rau_pkg::ST_MUL0;
            rau_pkg::ST_MUL0:      state_next = rau_pkg::ST_MUL1;
            rau_pkg::ST_MUL1:      state_next = rau_pkg::ST_MUL2;
            rau_pkg::ST_MUL2:      state_next = rau_pkg::ST_COMBINE;
            rau_pkg::ST_COMBINE:   state_next = rau_pkg::ST_GCD_CHECK;
            rau_pkg::ST_GCD_CHECK:
            begin
                if (stat.early_done)
                    state_next = rau_pkg::ST_FINISH;
                else if (stat.gcd_zero)
                    state_next = rau_pkg::ST_DIV_NUM;
                else
                    state_next = rau_pkg::ST_GCD_STEP;
            end
            rau_pkg::ST_GCD_STEP:
            begin
                wait_next = 1'b1;
                if (wait_reg && stat.div_done)
                    state_next = rau_pkg::ST_GCD_CHECK;
            end
            rau_pkg::ST_DIV_NUM:
            begin
                wait_next = 1'b1;
                if (wait_reg && stat.div_done)
                    state_next = rau_pkg::ST_DIV_DEN;
            end
            rau_pkg::ST_DIV_DEN:
            begin
                wait_next = 1'b1;
                if (wait_reg && stat.div_done)
                    state_next = rau_pkg::ST_FINISH;
            end
            rau_pkg::ST_FINISH:    state_next = rau_pkg::ST_OUT;
            rau_pkg::ST_OUT:       if (out_fire) state_next = rau_pkg::ST_IDLE;
            default:               state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl            = '0;
        ctrl.load       = in_fire;
        ctrl.mul_first  = (state_reg == rau_pkg::ST_MUL0);
        ctrl.mul_second = (state_reg == rau_pkg::ST_MUL1);
        ctrl.mul_third  = (state_reg == rau_pkg::ST_MUL2);
        ctrl.combine    = (state_reg == rau_pkg::ST_COMBINE);
        ctrl.gcd_go     = (state_reg == rau_pkg::ST_GCD_STEP) && !wait_reg;
        ctrl.gcd_start  = (state_reg == rau_pkg::ST_GCD_STEP) && wait_reg;
        ctrl.div_num    = (state_reg == rau_pkg::ST_DIV_NUM) && !wait_reg;
        ctrl.div_den    = (state_reg == rau_pkg::ST_DIV_DEN) && !wait_reg;
        ctrl.finish     = (state_reg == rau_pkg::ST_FINISH);
        in_ready        = (state_reg == rau_pkg::ST_IDLE);
        out_valid       = (state_reg == rau_pkg::ST_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::ST_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next && !(wait_reg && stat.div_done);
        end
    end

    logic unused_ok;
    assign unused_ok = stat.div_busy;

endmodule

>>> design/rational_arithmetic_unit_top.sv
// ============================================================================
// rational_arithmetic_unit_top: fraction add, subtract, multiply, divide
// and compare, with the result reduced to lowest terms by Euclid's GCD.
// ============================================================================
//
//  Channel | Signals                      | Direction | Payload
//  --------+------------------------------+-----------+----------------------
//  input   | in_valid, in_ready, in_data  | in        | rau_pkg::in_item_t
//  output  | out_valid, out_ready, out_data| out      | rau_pkg::out_item_t
//
// One beat is processed at a time; in_ready is low from acceptance until
// the result beat is taken. Compares and invalid operands skip the Euclid
// steps and the two divisions; the shared divider, used for a reduced
// fraction, produces one quotient bit per cycle.
// Reset is asynchronous and active low; it returns the sequencer to idle.
// A stalled result simply holds in its output register.
//
// The order of work: the states MUL0, MUL1 and MUL2 drive the single shared
// multiplier to form the cross products, ST_COMBINE combines and takes
// magnitudes, then the divider runs the remainder loop of Euclid's algorithm
// and finally divides numerator and denominator by the GCD. The sign is moved
// onto the numerator so the denominator of a valid result is always positive.
//
module rational_arithmetic_unit_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rau_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rau_pkg::out_item_t out_data
);

    rau_pkg::ctrl_t ctrl;
    rau_pkg::stat_t stat;
    logic           in_fire;
    logic           out_fire;

    // Handshake completion on each side.
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    rau_sequencer u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .stat      (stat),
        .ctrl      (ctrl),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    rau_datapath u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .ctrl    (ctrl),
        .stat    (stat),
        .result  (out_data)
    );

endmodule

>>> design/rau_checker.sv
// ============================================================================
// rau_checker: port-level checks for the rational arithmetic unit
// Watches handshakes and result fields on the top-level ports.
// ============================================================================
module rau_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input rau_pkg::out_item_t out_data,
    input logic               out_valid,
    input logic               out_ready
);

    // The block never accepts while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // Accepting an item drops ready on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after accept");

    // A valid result denominator is never negative.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_data.res_denominator[31])
        else $error("negative denominator");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("result changed while stalled");

endmodule

bind rational_arithmetic_unit_top rau_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
